// File: src/fsr_pkg.sv
`timescale 1ns / 1ps
package fsr_pkg;

  localparam int FRAC       = 28;
  localparam int QW         = 29;
  localparam int CW         = 30;
  localparam int WIDE_W     = 58;
  localparam int DEN_W      = 30;
  localparam int DIV_STEPS  = 29;
  localparam int SQRT_STEPS = 29;
  localparam int MUL_STEPS  = 4;
  localparam int OUT_W      = 16;
  localparam int RND_SHIFT  = 13;

  localparam logic [QW-1:0]    ONE_Q   = QW'(1) << FRAC;
  localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(32768);

  typedef struct packed {
    logic [OUT_W-1:0] reflectance;
    logic             total_internal;
  } result_t;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic                 gt;
    logic                 tir;
    logic                 dz;
    logic                 sz;
  } div_side_t;

  typedef struct packed {
    logic [QW-1:0]        r0;
    logic signed [CW-1:0] c;
    logic                 gt;
    logic                 tir;
  } sq_side_t;

  // Q.28 product, truncated back to Q.28; operands and result within [0, 1.0]
  function automatic logic [QW-1:0] mul_q(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [WIDE_W-1:0] pr;
    pr = WIDE_W'(a) * WIDE_W'(b);
    return pr[FRAC+QW-1:FRAC];
  endfunction

endpackage

// File: src/fsr_div.sv
`timescale 1ns / 1ps
module fsr_div import fsr_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WIDE_W-1:0] num,
  input  logic [DEN_W-1:0]  den,
  output logic [QW-1:0]     quo
);

  logic [WIDE_W-1:0] rem_q   [DIV_STEPS];
  logic [DEN_W-1:0]  den_q   [DIV_STEPS];
  logic [QW-1:0]     quo_q   [DIV_STEPS];
  logic [WIDE_W-1:0] rem_src [DIV_STEPS];
  logic [DEN_W-1:0]  den_src [DIV_STEPS];
  logic [QW-1:0]     quo_src [DIV_STEPS];
  logic [WIDE_W-1:0] rem_next [DIV_STEPS];
  logic [QW-1:0]     quo_next [DIV_STEPS];
  logic [WIDE_W-1:0] trial   [DIV_STEPS];

  // one quotient bit per stage, MSB first; quotient assumed below 2^QW
  always_comb begin
    rem_src[0] = num;
    den_src[0] = den;
    quo_src[0] = '0;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_src[k] = rem_q[k-1];
      den_src[k] = den_q[k-1];
      quo_src[k] = quo_q[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = WIDE_W'(den_src[k]) << (DIV_STEPS - 1 - k);
      if (rem_src[k] >= trial[k]) begin
        rem_next[k] = rem_src[k] - trial[k];
        quo_next[k] = quo_src[k] | (QW'(1) << (DIV_STEPS - 1 - k));
      end else begin
        rem_next[k] = rem_src[k];
        quo_next[k] = quo_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_q[k] <= rem_next[k];
        den_q[k] <= den_src[k];
        quo_q[k] <= quo_next[k];
      end
    end
  end

  assign quo = quo_q[DIV_STEPS-1];

endmodule

// File: src/fsr_sqrt.sv
`timescale 1ns / 1ps
module fsr_sqrt import fsr_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WIDE_W-1:0] rad,
  output logic [QW-1:0]     root
);

  logic [WIDE_W-1:0] rem_q    [SQRT_STEPS];
  logic [QW-1:0]     root_q   [SQRT_STEPS];
  logic [WIDE_W-1:0] rem_src  [SQRT_STEPS];
  logic [QW-1:0]     root_src [SQRT_STEPS];
  logic [WIDE_W-1:0] rem_next [SQRT_STEPS];
  logic [QW-1:0]     root_next [SQRT_STEPS];
  logic [WIDE_W-1:0] trial    [SQRT_STEPS];

  // rem holds rad - root^2; trying bit b adds 2*root*2^b + 2^2b
  always_comb begin
    rem_src[0]  = rad;
    root_src[0] = '0;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      rem_src[k]  = rem_q[k-1];
      root_src[k] = root_q[k-1];
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      trial[k] = (WIDE_W'(root_src[k]) << (SQRT_STEPS - k))
               | (WIDE_W'(1) << (2 * (SQRT_STEPS - 1 - k)));
      if (rem_src[k] >= trial[k]) begin
        rem_next[k]  = rem_src[k] - trial[k];
        root_next[k] = root_src[k] | (QW'(1) << (SQRT_STEPS - 1 - k));
      end else begin
        rem_next[k]  = rem_src[k];
        root_next[k] = root_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
      end
    end
  end

  assign root = root_q[SQRT_STEPS-1];

endmodule

// File: src/fsr_skid.sv
`timescale 1ns / 1ps
module fsr_skid import fsr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    full,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_stall
);

  result_t skid;
  logic    in_xfer;

  assign in_xfer = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full      <= 1'b0;
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (full) begin
        out_data  <= skid;
        out_valid <= 1'b1;
        full      <= 1'b0;
      end else begin
        out_data  <= in_data;
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid <= in_data;
      full <= 1'b1;
    end
  end

endmodule

// File: src/fresnel_schlick_reflectance_unit.sv
`timescale 1ns / 1ps
// Schlick Fresnel reflectance, fully pipelined.
// Sections in order from input transfer to out_valid: dot/setup, divide, radicand,
// square root, power and blend, output skid; throughput one item per cycle while in_stall is low.
// The pipeline advances whenever the output skid register is empty; in_stall is registered.
// Synchronous active-high reset clears all valid bits and the skid; payload is not reset.
module fresnel_schlick_reflectance_unit import fsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] eye_x,
  input  logic signed [15:0] eye_y,
  input  logic signed [15:0] eye_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [13:0]        index_from,
  input  logic [13:0]        index_into,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        reflectance,
  output logic               total_internal
);

  localparam logic signed [33:0] LIM_D = 34'sd268435456;
  localparam logic signed [CW-1:0] ONE_C = CW'(268435456);
  localparam logic [WIDE_W-1:0] ONE_SQ = WIDE_W'(1) << (2 * FRAC);

  logic full, en;
  assign en       = !full;
  assign in_stall = full;

  // stage 1: products
  logic               v1;
  logic signed [31:0] pxx, pyy, pzz;
  logic [13:0]        n1_1, n2_1;
  // stage 2: dot clamp, index terms
  logic               v2, gt2;
  logic signed [CW-1:0] c2;
  logic [13:0]        d2;
  logic [14:0]        s2;
  logic [27:0]        n1sq2, n2sq2;
  logic signed [33:0] dsum;
  // stage 3
  logic               v3, gt3;
  logic signed [CW-1:0] c3;
  logic [QW-1:0]      ac3;
  logic [27:0]        n1sq3, n2sq3, dsq3;
  logic [29:0]        ssq3;
  // stage 4
  logic               v4, gt4;
  logic signed [CW-1:0] c4;
  logic [WIDE_W-1:0]  acsq4;
  logic [27:0]        n1sq4, n2sq4, dsq4;
  logic [29:0]        ssq4;
  // stage 5
  logic               v5, gt5;
  logic signed [CW-1:0] c5;
  logic [QW-1:0]      omc5;
  logic [27:0]        n1sq5, n2sq5, dsq5;
  logic [29:0]        ssq5;
  // stage 6
  logic               v6, gt6;
  logic signed [CW-1:0] c6;
  logic [WIDE_W-1:0]  num6;
  logic [27:0]        n2sq6, dsq6;
  logic [29:0]        ssq6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  assign dsum = 34'(pxx) + 34'(pyy) + 34'(pzz);

  always_ff @(posedge clk) begin
    if (en) begin
      pxx  <= eye_x * normal_x;
      pyy  <= eye_y * normal_y;
      pzz  <= eye_z * normal_z;
      n1_1 <= index_from;
      n2_1 <= index_into;

      if (dsum > LIM_D) begin
        c2 <= ONE_C;
      end else if (dsum < -LIM_D) begin
        c2 <= -ONE_C;
      end else begin
        c2 <= CW'(dsum);
      end
      gt2   <= n1_1 > n2_1;
      d2    <= (n1_1 > n2_1) ? (n1_1 - n2_1) : (n2_1 - n1_1);
      s2    <= 15'(n1_1) + 15'(n2_1);
      n1sq2 <= 28'(n1_1) * 28'(n1_1);
      n2sq2 <= 28'(n2_1) * 28'(n2_1);

      ac3   <= (c2 < 0) ? QW'(-c2) : QW'(c2);
      dsq3  <= 28'(d2) * 28'(d2);
      ssq3  <= 30'(s2) * 30'(s2);
      c3    <= c2;  gt3 <= gt2;
      n1sq3 <= n1sq2; n2sq3 <= n2sq2;

      acsq4 <= WIDE_W'(ac3) * WIDE_W'(ac3);
      c4    <= c3;  gt4 <= gt3;
      n1sq4 <= n1sq3; n2sq4 <= n2sq3; dsq4 <= dsq3; ssq4 <= ssq3;

      omc5  <= QW'((ONE_SQ - acsq4) >> FRAC);
      c5    <= c4;  gt5 <= gt4;
      n1sq5 <= n1sq4; n2sq5 <= n2sq4; dsq5 <= dsq4; ssq5 <= ssq4;

      num6  <= WIDE_W'(n1sq5) * WIDE_W'(omc5);
      c6    <= c5;  gt6 <= gt5;
      n2sq6 <= n2sq5; dsq6 <= dsq5; ssq6 <= ssq5;
    end
  end

  // divide section: sin2 = num/den and r0 = d^2/s^2 side by side
  div_side_t ds_in;
  div_side_t ds_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_q;
  logic [QW-1:0] sin2_q, r0_q;

  always_comb begin
    ds_in.c   = c6;
    ds_in.gt  = gt6;
    ds_in.tir = gt6 && (num6 > (WIDE_W'(n2sq6) << FRAC));
    ds_in.dz  = (n2sq6 == '0);
    ds_in.sz  = (ssq6 == '0);
  end

  fsr_div u_div_sin2 (
    .clk (clk),
    .en  (en),
    .num (num6),
    .den (DEN_W'(n2sq6)),
    .quo (sin2_q)
  );

  fsr_div u_div_r0 (
    .clk (clk),
    .en  (en),
    .num (WIDE_W'(dsq6) << FRAC),
    .den (ssq6),
    .quo (r0_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_q <= '0;
    end else if (en) begin
      dv_q <= {dv_q[DIV_STEPS-2:0], v6};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_q[0] <= ds_in;
      for (int k = 1; k < DIV_STEPS; k++) begin
        ds_q[k] <= ds_q[k-1];
      end
    end
  end

  // stage P: square root radicand
  div_side_t     dso;
  logic [QW-1:0] sin2, r0;
  logic          vp;
  logic [WIDE_W-1:0] rad_p;
  sq_side_t      sp;

  assign dso = ds_q[DIV_STEPS-1];

  always_comb begin
    if (dso.dz) begin
      sin2 = '0;
    end else if (sin2_q > ONE_Q) begin
      sin2 = ONE_Q;
    end else begin
      sin2 = sin2_q;
    end
    if (dso.sz) begin
      r0 = '0;
    end else if (r0_q > ONE_Q) begin
      r0 = ONE_Q;
    end else begin
      r0 = r0_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= dv_q[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_p  <= WIDE_W'(ONE_Q - sin2) << FRAC;
      sp.r0  <= r0;
      sp.c   <= dso.c;
      sp.gt  <= dso.gt;
      sp.tir <= dso.tir;
    end
  end

  // square root section
  logic [QW-1:0] root;
  sq_side_t ss_q [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sv_q;

  fsr_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad_p),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[SQRT_STEPS-2:0], vp};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ss_q[0] <= sp;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        ss_q[k] <= ss_q[k-1];
      end
    end
  end

  // stage X: x = 1 - cos; x >= 1.0 always saturates the result, so clamp it there
  sq_side_t ssx;
  logic signed [CW-1:0] cf;
  logic signed [CW:0]   xs;
  logic          vx, tirx;
  logic [QW-1:0] xx, omrx, r0x;

  assign ssx = ss_q[SQRT_STEPS-1];
  assign cf  = ssx.gt ? $signed({1'b0, root}) : ssx.c;
  assign xs  = (CW+1)'(ONE_C) - (CW+1)'(cf);

  always_ff @(posedge clk) begin
    if (rst) begin
      vx <= 1'b0;
    end else if (en) begin
      vx <= sv_q[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx   <= (xs >= (CW+1)'(ONE_C)) ? ONE_Q : xs[QW-1:0];
      omrx <= ONE_Q - ssx.r0;
      r0x  <= ssx.r0;
      tirx <= ssx.tir;
    end
  end

  // power stages: x^5 by four truncating multiplies
  logic [QW-1:0] pm [MUL_STEPS];
  logic [QW-1:0] xm [MUL_STEPS];
  logic [QW-1:0] omrm [MUL_STEPS];
  logic [QW-1:0] r0m [MUL_STEPS];
  logic          tirm [MUL_STEPS];
  logic [MUL_STEPS-1:0] vm;
  logic [QW-1:0] p_src [MUL_STEPS];
  logic [QW-1:0] x_src [MUL_STEPS];
  logic [QW-1:0] omr_src [MUL_STEPS];
  logic [QW-1:0] r0_src [MUL_STEPS];
  logic          tir_src [MUL_STEPS];

  always_comb begin
    p_src[0]   = xx;
    x_src[0]   = xx;
    omr_src[0] = omrx;
    r0_src[0]  = r0x;
    tir_src[0] = tirx;
    for (int k = 1; k < MUL_STEPS; k++) begin
      p_src[k]   = pm[k-1];
      x_src[k]   = xm[k-1];
      omr_src[k] = omrm[k-1];
      r0_src[k]  = r0m[k-1];
      tir_src[k] = tirm[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= '0;
    end else if (en) begin
      vm <= {vm[MUL_STEPS-2:0], vx};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MUL_STEPS; k++) begin
        pm[k]   <= mul_q(p_src[k], x_src[k]);
        xm[k]   <= x_src[k];
        omrm[k] <= omr_src[k];
        r0m[k]  <= r0_src[k];
        tirm[k] <= tir_src[k];
      end
    end
  end

  // blend: r0 + (1 - r0) * x^5, then round to Q1.15
  logic          vr, tirr, vf;
  logic [QW-1:0] prodr, r0r;
  logic [QW:0]   sum;
  logic [QW:0]   rnd;
  result_t       rf, res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
      vf <= 1'b0;
    end else if (en) begin
      vr <= vm[MUL_STEPS-1];
      vf <= vr;
    end
  end

  assign sum = (QW+1)'(r0r) + (QW+1)'(prodr);
  assign rnd = (sum + (QW+1)'(1 << (RND_SHIFT - 1))) >> RND_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      prodr <= mul_q(omrm[MUL_STEPS-1], pm[MUL_STEPS-1]);
      r0r   <= r0m[MUL_STEPS-1];
      tirr  <= tirm[MUL_STEPS-1];

      rf.total_internal <= tirr;
      if (tirr || (rnd > (QW+1)'(OUT_ONE))) begin
        rf.reflectance <= OUT_ONE;
      end else begin
        rf.reflectance <= rnd[OUT_W-1:0];
      end
    end
  end

  fsr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vf),
    .in_data   (rf),
    .full      (full),
    .out_valid (out_valid),
    .out_data  (res_out),
    .out_stall (out_stall)
  );

  assign reflectance    = res_out.reflectance;
  assign total_internal = res_out.total_internal;

endmodule

// File: dv/fresnel_schlick_reflectance_unit_test.sv
`timescale 1ns / 1ps
module fresnel_schlick_reflectance_unit_test;
  import fsr_pkg::*;

  localparam int LATENCY   = 73;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 800;

  typedef struct {
    logic signed [15:0] ex, ey, ez, nx, ny, nz;
    logic [13:0]        n_from, n_into;
  } ray_t;

  typedef struct {
    logic [15:0] refl;
    logic        tir;
  } fresnel_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] eye_x, eye_y, eye_z;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic [13:0]        index_from, index_into;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        reflectance;
  logic               total_internal;

  fresnel_t expected_q[$];
  int       n_errors;
  int       n_sent;
  int       n_checked;
  int       n_tir;
  int       idle_cycles;
  bit       quiet_mode;

  fresnel_schlick_reflectance_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] acc;
    logic [63:0] bitv;
    acc  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v   = v - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  function automatic fresnel_t schlick_reflectance(input ray_t r);
    fresnel_t    o;
    logic signed [63:0] dotp, cosv, lim;
    logic [63:0] a1, a2, ac, omc2, num, den, sin2, x, pw, d, s, r0, sum, res;
    logic [127:0] wide;
    lim  = 64'sd1 <<< 28;
    dotp = 64'(r.ex) * 64'(r.nx) + 64'(r.ey) * 64'(r.ny) + 64'(r.ez) * 64'(r.nz);
    if (dotp > lim) dotp = lim;
    if (dotp < -lim) dotp = -lim;
    cosv = dotp;
    a1 = 64'(r.n_from);
    a2 = 64'(r.n_into);
    if (a1 > a2) begin
      ac   = (cosv < 0) ? 64'(-cosv) : 64'(cosv);
      omc2 = ((64'd1 << 56) - ac * ac) >> 28;
      num  = a1 * a1 * omc2;
      den  = a2 * a2;
      if (num > (den << 28)) begin
        o.refl = OUT_ONE;
        o.tir  = 1'b1;
        return o;
      end
      sin2 = (den != 0) ? num / den : 64'd0;
      if (sin2 > (64'd1 << 28)) sin2 = 64'd1 << 28;
      cosv = $signed(floor_sqrt(((64'd1 << 28) - sin2) << 28));
    end
    x  = 64'(lim - cosv);
    pw = x;
    for (int k = 0; k < 4; k++) begin
      wide = 128'(pw) * 128'(x);
      pw   = 64'(wide >> 28);
    end
    d  = (a1 > a2) ? a1 - a2 : a2 - a1;
    s  = a1 + a2;
    r0 = (s != 0) ? ((d * d) << 28) / (s * s) : 64'd0;
    if (r0 > (64'd1 << 28)) r0 = 64'd1 << 28;
    wide = 128'((64'd1 << 28) - r0) * 128'(pw);
    sum  = r0 + 64'(wide >> 28);
    res  = (sum + (64'd1 << 12)) >> 13;
    if (res > 64'd32768) res = 64'd32768;
    o.refl = res[15:0];
    o.tir  = 1'b0;
    return o;
  endfunction

  // one transfer on the input side, with optional random gap first
  task automatic send_ray(input ray_t r);
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    eye_x      <= r.ex;
    eye_y      <= r.ey;
    eye_z      <= r.ez;
    normal_x   <= r.nx;
    normal_y   <= r.ny;
    normal_z   <= r.nz;
    index_from <= r.n_from;
    index_into <= r.n_into;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(schlick_reflectance(r));
    n_sent++;
  endtask

  function automatic ray_t make_ray(input int ex, ey, ez, nx, ny, nz, f, t);
    ray_t r;
    r.ex = 16'(ex); r.ey = 16'(ey); r.ez = 16'(ez);
    r.nx = 16'(nx); r.ny = 16'(ny); r.nz = 16'(nz);
    r.n_from = 14'(f); r.n_into = 14'(t);
    return r;
  endfunction

  function automatic int rand_comp();
    case ($urandom_range(0, 5))
      0: return 16384;
      1: return -16384;
      2: return 0;
      3: return $urandom_range(0, 2000) - 1000;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  function automatic int rand_index();
    case ($urandom_range(0, 4))
      0: return 4096;
      1: return 16383;
      2: return $urandom_range(4096, 6500);
      default: return $urandom_range(4096, 16383);
    endcase
  endfunction

  task automatic run_directed_extremes();
    send_ray(make_ray(16384, 0, 0, 16384, 0, 0, 4096, 4096));
    send_ray(make_ray(16384, 0, 0, -16384, 0, 0, 4096, 6144));
    send_ray(make_ray(0, 16384, 0, 0, 0, 16384, 4096, 6144));
    send_ray(make_ray(0, 0, 16384, 0, 0, 16384, 6144, 4096));
    send_ray(make_ray(16384, 16384, 16384, 16384, 16384, 16384, 16383, 4096));
    // unnormalized, clamps to -1
    send_ray(make_ray(-16384, -16384, -16384, 16384, 16384, 16384, 4096, 16383));
    // grazing from dense medium: total internal reflection
    send_ray(make_ray(16384, 0, 0, 0, 16384, 0, 6144, 4096));
    send_ray(make_ray(11585, 0, 0, 11585, 0, 0, 6144, 4096));
    send_ray(make_ray(15000, 0, 0, 16384, 0, 0, 5000, 4096));
    send_ray(make_ray(-16384, 0, 0, 11585, 0, 0, 16383, 16383));
    send_ray(make_ray(-32768, -1, 32767, 32767, -32768, -1, 16383, 16382));
    send_ray(make_ray(1, -1, 1, -1, 1, -1, 4097, 4096));
  endtask

  task automatic run_random_rays(input int count);
    ray_t r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        // raw bits so every input bit toggles
        r = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
      end else begin
        r = make_ray(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                     rand_comp(), rand_index(), rand_index());
      end
      send_ray(r);
    end
  endtask

  task automatic run_back_to_back(input int count);
    quiet_mode = 1'b1;
    run_random_rays(count);
  endtask

  // output stall generator
  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (!quiet_mode && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    fresnel_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transfer: reflectance=%0d total_internal=%0b",
               reflectance, total_internal);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (e.tir) n_tir++;
        if (reflectance !== e.refl) begin
          $error("reflectance expected %0d actual %0d", e.refl, reflectance);
          n_errors++;
        end
        if (total_internal !== e.tir) begin
          $error("total_internal expected %0b actual %0b", e.tir, total_internal);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("watchdog: no transfer for %0d cycles", WDOG_MAX);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int drain;
    rst        = 1'b1;
    in_valid   = 1'b0;
    eye_x      = '0; eye_y = '0; eye_z = '0;
    normal_x   = '0; normal_y = '0; normal_z = '0;
    index_from = 14'd4096;
    index_into = 14'd4096;
    n_sent     = 0;
    quiet_mode = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed_extremes();
    run_random_rays(N_RANDOM - 150);
    run_back_to_back(150);
    in_valid <= 1'b0;

    drain = 0;
    while (expected_q.size() != 0 && drain < 50000) begin
      @(posedge clk);
      drain++;
    end
    repeat (LATENCY + 10) @(posedge clk);

    $display("sent %0d rays, checked %0d results (%0d total internal reflection)",
             n_sent, n_checked, n_tir);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, expected_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
